### sv/cau_pkg.sv
// cau_pkg: types, constants and helper functions for the complex arithmetic unit.
// No dependencies; used by complex_arith_unit_top through scoped names.

package cau_pkg;

  // operation codes carried in the input tuser
  typedef enum logic [2:0] {
    FUNC_ADD = 3'd0,
    FUNC_SUB = 3'd1,
    FUNC_MUL = 3'd2,
    FUNC_DIV = 3'd3,
    FUNC_MAG = 3'd4,
    FUNC_EQU = 3'd5
  } func_e_t;

  localparam int unsigned DivSteps = 33;   // quotient bits: 16 integer, 16 fraction, 1 round
  localparam logic [31:0] PosMax   = 32'h7FFF_FFFF;
  localparam logic [31:0] NegMax   = 32'h8000_0000;

  // one clamped result part
  typedef struct packed {
    logic [31:0] val;
    logic        sat;
  } part_t;

  // stage after the multipliers
  typedef struct packed {
    func_e_t            func;
    logic signed [63:0] p1;
    logic signed [63:0] p2;
    logic signed [63:0] p3;
    logic signed [63:0] p4;
    logic        [63:0] p5;
    logic        [63:0] p6;
    logic        [31:0] er;
    logic        [31:0] ei;
    logic               eeq;
    logic               esat;
  } s0_t;

  // stage after the product sums, sign and magnitude form
  typedef struct packed {
    func_e_t     func;
    logic        neg0;
    logic [63:0] mag0;
    logic        neg1;
    logic [63:0] mag1;
    logic [63:0] den;
    logic [31:0] er;
    logic [31:0] ei;
    logic        eeq;
    logic        esat;
  } s1_t;

  // divider stage word: partial remainder and quotient shift word per part
  typedef struct packed {
    func_e_t     func;
    logic        neg0;
    logic        neg1;
    logic        ovf0;
    logic        ovf1;
    logic [63:0] rem0;
    logic [63:0] rem1;
    logic [32:0] w0;
    logic [32:0] w1;
    logic [63:0] den;
    logic [31:0] er;
    logic [31:0] ei;
    logic        eeq;
    logic        dz;
    logic        esat;
  } dv_t;

  typedef struct packed {
    logic [63:0] rem;
    logic [32:0] w;
  } dstep_t;

  // result word as it leaves on the output channel
  typedef struct packed {
    logic [31:0] res_real;
    logic [31:0] res_imag;
    logic        eq;
    logic        dz;
    logic        sat;
  } out_t;

  // clamp a 33-bit signed sum to 32 bits
  function automatic part_t sat33(logic signed [32:0] s);
    part_t r;
    r.sat = (s[32] != s[31]);
    if (r.sat) begin
      r.val = s[32] ? NegMax : PosMax;
    end else begin
      r.val = s[31:0];
    end
    return r;
  endfunction

  // clamp a sign and magnitude value to signed 32 bits
  function automatic part_t clamp_sm(logic neg, logic [63:0] mag);
    part_t r;
    r.sat = 1'b0;
    if (!neg) begin
      if (mag > {32'd0, PosMax}) begin
        r.val = PosMax;
        r.sat = 1'b1;
      end else begin
        r.val = mag[31:0];
      end
    end else if (mag > {32'd0, NegMax}) begin
      r.val = NegMax;
      r.sat = 1'b1;
    end else begin
      r.val = ~mag[31:0] + 32'd1;
    end
    return r;
  endfunction

  // one restoring division step: shift in the next dividend bit, subtract if it fits
  function automatic dstep_t div_step(logic [63:0] rem, logic [32:0] w, logic [63:0] den);
    dstep_t      r;
    logic [64:0] r2;
    logic        ge;
    r2    = {rem, w[32]};
    ge    = (r2 >= {1'b0, den});
    r.rem = ge ? 64'(r2 - {1'b0, den}) : r2[63:0];
    r.w   = {w[31:0], ge};
    return r;
  endfunction

endpackage

### sv/complex_arith_unit_top.sv
// complex_arith_unit_top: pipelined complex add, sub, mul, div, |A|^2 and equality.
// Depends on cau_pkg for types, the divider step and the clamping functions.
//
//  channel | dir | signals                                  | content
//  in_     | in  | in_tvalid, in_tready, in_tdata, in_tuser | operands and operation code
//  out_    | out | out_tvalid, out_tready, out_tdata, ...   | result parts and flags
//  cfg_    | in  | cfg_wr_en, cfg_wr_data                   | equality tolerance
//
// One word enters per cycle while the skid register is empty; each word passes the
// product stages, the 33-step restoring divider chain and the output register.
// rst_n (synchronous) empties the pipeline and sets the tolerance to 1.
// The whole pipeline holds while the skid register is full; the output register
// and the skid register keep the input side taking words while a result waits.

module complex_arith_unit_top (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,   // a_real, a_imag, b_real, b_imag
  input  logic [2:0]   in_tuser,   // func
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [63:0]  out_tdata,  // res_real, res_imag
  output logic [2:0]   out_tuser,  // equal_flag, div_zero, saturated
  input  logic         cfg_wr_en,
  input  logic [30:0]  cfg_wr_data
);

  localparam int unsigned Steps = cau_pkg::DivSteps;

  logic [30:0] tol_r;
  logic        en;

  cau_pkg::s0_t s0_r, s0_nxt;
  cau_pkg::s1_t s1_r, s1_nxt;
  cau_pkg::dv_t dv_r [0:Steps];
  cau_pkg::dv_t dv_nxt [0:Steps];
  logic         v0_r, v1_r;
  logic [Steps:0] dvv_r;

  cau_pkg::out_t fin;
  cau_pkg::out_t out_r, skid_r;
  logic          out_vld_r, skid_vld_r;

  // tolerance register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= 31'd1;
    end else if (cfg_wr_en) begin
      tol_r <= cfg_wr_data;
    end
  end

  // advance the pipeline while the skid register is free
  assign en        = !skid_vld_r;
  assign in_tready = en;

  // stage 0: multipliers, plus add, sub and equality in full
  always_comb begin
    logic signed [31:0] ar, ai, br, bi, m1b, m2b;
    logic signed [32:0] dr, di;
    logic        [32:0] adr, adi;
    cau_pkg::part_t     pr, pi;
    ar  = in_tdata[31:0];
    ai  = in_tdata[63:32];
    br  = in_tdata[95:64];
    bi  = in_tdata[127:96];
    s0_nxt.func = cau_pkg::func_e_t'(in_tuser);
    // |A|^2 reuses the first two multipliers with A on both inputs
    m1b = (s0_nxt.func == cau_pkg::FUNC_MAG) ? ar : br;
    m2b = (s0_nxt.func == cau_pkg::FUNC_MAG) ? ai : bi;
    s0_nxt.p1 = 64'(ar * m1b);
    s0_nxt.p2 = 64'(ai * m2b);
    s0_nxt.p3 = 64'(ar * bi);
    s0_nxt.p4 = 64'(ai * br);
    s0_nxt.p5 = 64'(br * br);
    s0_nxt.p6 = 64'(bi * bi);
    s0_nxt.er   = '0;
    s0_nxt.ei   = '0;
    s0_nxt.eeq  = 1'b0;
    s0_nxt.esat = 1'b0;
    dr  = 33'(ar) - 33'(br);
    di  = 33'(ai) - 33'(bi);
    adr = dr[32] ? 33'(-dr) : 33'(dr);
    adi = di[32] ? 33'(-di) : 33'(di);
    pr  = '0;
    pi  = '0;
    case (s0_nxt.func)
      cau_pkg::FUNC_ADD: begin
        pr = cau_pkg::sat33(33'(ar) + 33'(br));
        pi = cau_pkg::sat33(33'(ai) + 33'(bi));
      end
      cau_pkg::FUNC_SUB: begin
        pr = cau_pkg::sat33(dr);
        pi = cau_pkg::sat33(di);
      end
      cau_pkg::FUNC_EQU: begin
        s0_nxt.eeq = (adr < {2'b00, tol_r}) && (adi < {2'b00, tol_r});
      end
      default: begin
        pr = '0;
        pi = '0;
      end
    endcase
    s0_nxt.er   = pr.val;
    s0_nxt.ei   = pi.val;
    s0_nxt.esat = pr.sat | pi.sat;
  end

  // stage 1: sum the products into sign and magnitude
  always_comb begin
    logic signed [65:0] x1, x2, x3, x4, s0v, s1v;
    x1 = 66'(s0_r.p1);
    x2 = 66'(s0_r.p2);
    x3 = 66'(s0_r.p3);
    x4 = 66'(s0_r.p4);
    if (s0_r.func == cau_pkg::FUNC_MUL) begin
      s0v = x1 - x2;
      s1v = x3 + x4;
    end else begin
      s0v = x1 + x2;
      s1v = x4 - x3;
    end
    s1_nxt.func = s0_r.func;
    s1_nxt.neg0 = s0v[65];
    s1_nxt.mag0 = s0v[65] ? 64'(-s0v) : s0v[63:0];
    s1_nxt.neg1 = s1v[65];
    s1_nxt.mag1 = s1v[65] ? 64'(-s1v) : s1v[63:0];
    s1_nxt.den  = s0_r.p5 + s0_r.p6;
    s1_nxt.er   = s0_r.er;
    s1_nxt.ei   = s0_r.ei;
    s1_nxt.eeq  = s0_r.eeq;
    s1_nxt.esat = s0_r.esat;
  end

  // stage 2: round mul and |A|^2, set up the dividers
  always_comb begin
    cau_pkg::part_t pr, pi;
    dv_nxt[0].func = s1_r.func;
    dv_nxt[0].neg0 = s1_r.neg0;
    dv_nxt[0].neg1 = s1_r.neg1;
    dv_nxt[0].den  = s1_r.den;
    // quotient of 65536 or more saturates either way
    dv_nxt[0].ovf0 = ({16'd0, s1_r.mag0} >= {s1_r.den, 16'd0});
    dv_nxt[0].ovf1 = ({16'd0, s1_r.mag1} >= {s1_r.den, 16'd0});
    dv_nxt[0].rem0 = {16'd0, s1_r.mag0[63:16]};
    dv_nxt[0].rem1 = {16'd0, s1_r.mag1[63:16]};
    dv_nxt[0].w0   = {s1_r.mag0[15:0], 17'd0};
    dv_nxt[0].w1   = {s1_r.mag1[15:0], 17'd0};
    dv_nxt[0].er   = s1_r.er;
    dv_nxt[0].ei   = s1_r.ei;
    dv_nxt[0].eeq  = s1_r.eeq;
    dv_nxt[0].esat = s1_r.esat;
    dv_nxt[0].dz   = 1'b0;
    pr = cau_pkg::clamp_sm(s1_r.neg0, (s1_r.mag0 + 64'h8000) >> 16);
    pi = cau_pkg::clamp_sm(s1_r.neg1, (s1_r.mag1 + 64'h8000) >> 16);
    case (s1_r.func)
      cau_pkg::FUNC_MUL: begin
        dv_nxt[0].er   = pr.val;
        dv_nxt[0].ei   = pi.val;
        dv_nxt[0].esat = pr.sat | pi.sat;
      end
      cau_pkg::FUNC_MAG: begin
        dv_nxt[0].er   = pr.val;
        dv_nxt[0].esat = pr.sat;
      end
      cau_pkg::FUNC_DIV: begin
        if (s1_r.den == 64'd0) begin
          dv_nxt[0].dz = 1'b1;
          dv_nxt[0].er = cau_pkg::PosMax;
          dv_nxt[0].ei = cau_pkg::PosMax;
        end
      end
      default: begin
        dv_nxt[0].dz = 1'b0;
      end
    endcase
  end

  // divider steps: one quotient bit per part in each stage
  for (genvar i = 1; i <= Steps; i++) begin : g_div
    always_comb begin
      cau_pkg::dstep_t d0, d1;
      d0 = cau_pkg::div_step(dv_r[i-1].rem0, dv_r[i-1].w0, dv_r[i-1].den);
      d1 = cau_pkg::div_step(dv_r[i-1].rem1, dv_r[i-1].w1, dv_r[i-1].den);
      dv_nxt[i]      = dv_r[i-1];
      dv_nxt[i].rem0 = d0.rem;
      dv_nxt[i].w0   = d0.w;
      dv_nxt[i].rem1 = d1.rem;
      dv_nxt[i].w1   = d1.w;
    end
  end

  // final: round the quotients, clamp, pick the result
  always_comb begin
    logic [33:0]    q0, q1;
    logic [32:0]    r0, r1;
    cau_pkg::part_t pr, pi;
    q0 = 34'(dv_r[Steps].w0) + 34'd1;
    q1 = 34'(dv_r[Steps].w1) + 34'd1;
    r0 = q0[33:1];
    r1 = q1[33:1];
    pr = cau_pkg::clamp_sm(dv_r[Steps].neg0 && (r0 != 33'd0), 64'(r0));
    pi = cau_pkg::clamp_sm(dv_r[Steps].neg1 && (r1 != 33'd0), 64'(r1));
    if (dv_r[Steps].ovf0) begin
      pr.val = dv_r[Steps].neg0 ? cau_pkg::NegMax : cau_pkg::PosMax;
      pr.sat = 1'b1;
    end
    if (dv_r[Steps].ovf1) begin
      pi.val = dv_r[Steps].neg1 ? cau_pkg::NegMax : cau_pkg::PosMax;
      pi.sat = 1'b1;
    end
    if (dv_r[Steps].func == cau_pkg::FUNC_DIV && !dv_r[Steps].dz) begin
      fin.res_real = pr.val;
      fin.res_imag = pi.val;
      fin.eq       = 1'b0;
      fin.dz       = 1'b0;
      fin.sat      = pr.sat | pi.sat;
    end else begin
      fin.res_real = dv_r[Steps].er;
      fin.res_imag = dv_r[Steps].ei;
      fin.eq       = dv_r[Steps].eeq;
      fin.dz       = dv_r[Steps].dz;
      fin.sat      = dv_r[Steps].esat;
    end
  end

  // pipeline valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r  <= 1'b0;
      v1_r  <= 1'b0;
      dvv_r <= '0;
    end else if (en) begin
      v0_r  <= in_tvalid;
      v1_r  <= v0_r;
      dvv_r <= {dvv_r[Steps-1:0], v1_r};
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    if (en) begin
      s0_r <= s0_nxt;
      s1_r <= s1_nxt;
      for (int k = 0; k <= Steps; k++) begin
        dv_r[k] <= dv_nxt[k];
      end
    end
  end

  // output register and skid register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      if (skid_vld_r) begin
        if (out_tready) begin
          out_r      <= skid_r;
          skid_vld_r <= 1'b0;
        end
      end else if (dvv_r[Steps]) begin
        if (!out_vld_r || out_tready) begin
          out_r     <= fin;
          out_vld_r <= 1'b1;
        end else begin
          skid_r     <= fin;
          skid_vld_r <= 1'b1;
        end
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {out_r.res_imag, out_r.res_real};
  assign out_tuser  = {out_r.sat, out_r.dz, out_r.eq};

  // a zero denominator never also reports clamping
  a_dz_no_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tuser[1] && out_tuser[2]))
    else $error("div_zero with saturated");

  // equality and zero denominator belong to different operations
  a_eq_dz: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tuser[0] && out_tuser[1]))
    else $error("equal_flag with div_zero");

  // an equality result carries zero parts
  a_eq_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> (out_tdata == 64'd0))
    else $error("equal result with non-zero parts");

  // a zero denominator gives the largest positive value in both parts
  a_dz_val: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[1]) |-> (out_tdata == {cau_pkg::PosMax, cau_pkg::PosMax}))
    else $error("div_zero result value");

  // the skid register only fills while the output is stalled
  a_skid: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_vld_r) |-> $past(out_vld_r && !out_tready))
    else $error("skid filled without stall");

endmodule

### dv/complex_arith_checker.sv
// complex_arith_checker: watches the input, result and tolerance ports of the complex
// arithmetic unit, predicts each result word and compares it field by field.
// Depends on cau_pkg for the operation codes and the clamp limits.

module complex_arith_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [127:0] in_tdata,
  input  logic [2:0]   in_tuser,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [63:0]  out_tdata,
  input  logic [2:0]   out_tuser,
  input  logic         cfg_wr_en,
  input  logic [30:0]  cfg_wr_data,
  output int           fail_count,
  output int           results_pending
);

  typedef struct packed {
    logic [31:0] res_real;
    logic [31:0] res_imag;
    logic        eq;
    logic        dz;
    logic        sat;
  } cau_result_t;

  cau_result_t result_fifo[$];
  logic [30:0] tol_q;

  // clamp a sign and magnitude value to signed 32 bits
  function automatic logic [31:0] clamp_part(logic neg, logic [65:0] mag, ref logic sat);
    if (!neg) begin
      if (mag > 66'(cau_pkg::PosMax)) begin
        sat = 1'b1;
        return cau_pkg::PosMax;
      end
      return mag[31:0];
    end
    if (mag > 66'(cau_pkg::NegMax)) begin
      sat = 1'b1;
      return cau_pkg::NegMax;
    end
    return ~mag[31:0] + 32'd1;
  endfunction

  // rounded Q16.16 quotient of an unsigned Q32.32 numerator magnitude over den
  function automatic logic [65:0] quot_mag(logic [65:0] nm, logic [65:0] den);
    logic [82:0] q17;
    if (nm / den >= 66'h10000) return 66'h1_0000_0000;
    q17 = {nm, 17'd0} / 83'(den);
    return 66'((q17 + 83'd1) >> 1);
  endfunction

  function automatic logic [65:0] abs66(logic signed [65:0] v);
    return v < 0 ? 66'(-v) : 66'(v);
  endfunction

  function automatic cau_result_t predict_result(logic [2:0] func, logic [127:0] ops,
                                                 logic [30:0] tol);
    cau_result_t        r;
    logic signed [65:0] ar, ai, br, bi, s0, s1, den;
    logic [65:0]        m0, m1;
    logic               sat;
    ar  = $signed(ops[31:0]);
    ai  = $signed(ops[63:32]);
    br  = $signed(ops[95:64]);
    bi  = $signed(ops[127:96]);
    r   = '0;
    sat = 1'b0;
    case (func)
      cau_pkg::FUNC_ADD, cau_pkg::FUNC_SUB: begin
        s0 = (func == cau_pkg::FUNC_ADD) ? ar + br : ar - br;
        s1 = (func == cau_pkg::FUNC_ADD) ? ai + bi : ai - bi;
        r.res_real = clamp_part(s0 < 0, abs66(s0), sat);
        r.res_imag = clamp_part(s1 < 0, abs66(s1), sat);
      end
      cau_pkg::FUNC_MUL: begin
        s0 = ar * br - ai * bi;
        s1 = ar * bi + ai * br;
        r.res_real = clamp_part(s0 < 0, (abs66(s0) + 66'h8000) >> 16, sat);
        r.res_imag = clamp_part(s1 < 0, (abs66(s1) + 66'h8000) >> 16, sat);
      end
      cau_pkg::FUNC_DIV: begin
        den = br * br + bi * bi;
        if (den == 0) begin
          r.res_real = cau_pkg::PosMax;
          r.res_imag = cau_pkg::PosMax;
          r.dz       = 1'b1;
        end else begin
          s0 = ar * br + ai * bi;
          s1 = ai * br - ar * bi;
          m0 = quot_mag(abs66(s0), den);
          m1 = quot_mag(abs66(s1), den);
          r.res_real = clamp_part(s0 < 0 && m0 != 0, m0, sat);
          r.res_imag = clamp_part(s1 < 0 && m1 != 0, m1, sat);
        end
      end
      cau_pkg::FUNC_MAG: begin
        s0 = ar * ar + ai * ai;
        r.res_real = clamp_part(1'b0, (66'(s0) + 66'h8000) >> 16, sat);
      end
      cau_pkg::FUNC_EQU: begin
        r.eq = (abs66(ar - br) < 66'(tol)) && (abs66(ai - bi) < 66'(tol));
      end
      default: ;
    endcase
    r.sat = sat;
    return r;
  endfunction

  // track tolerance, queue predictions, compare results
  always @(posedge clk) begin
    cau_result_t exp_w, got_w;
    if (!rst_n) begin
      tol_q <= 31'd1;
      result_fifo.delete();
      fail_count <= 0;
      results_pending <= 0;
    end else begin
      if (cfg_wr_en) tol_q <= cfg_wr_data;
      if (in_tvalid && in_tready) result_fifo.push_back(predict_result(in_tuser, in_tdata, tol_q));
      if (out_tvalid && out_tready) begin
        got_w = {out_tdata[31:0], out_tdata[63:32], out_tuser[0], out_tuser[1], out_tuser[2]};
        if (result_fifo.size() == 0) begin
          if (fail_count < 10) $display("unexpected result word %h", got_w);
          fail_count <= fail_count + 1;
        end else begin
          exp_w = result_fifo.pop_front();
          if (got_w !== exp_w) begin
            if (fail_count < 10)
              $display("mismatch: real exp %h got %h, imag exp %h got %h, eq %b/%b dz %b/%b sat %b/%b",
                       exp_w.res_real, got_w.res_real, exp_w.res_imag, got_w.res_imag,
                       exp_w.eq, got_w.eq, exp_w.dz, got_w.dz, exp_w.sat, got_w.sat);
            fail_count <= fail_count + 1;
          end
        end
      end
      results_pending <= result_fifo.size();
    end
  end

endmodule

### dv/tb_complex_arith_unit_top.sv
// tb_complex_arith_unit_top: drives operand words and tolerance writes into the complex
// arithmetic unit and gives the verdict. Depends on cau_pkg and complex_arith_checker.

module tb_complex_arith_unit_top;

  localparam logic [2:0] FuncSpare6 = 3'd6;
  localparam logic [2:0] FuncSpare7 = 3'd7;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [127:0] in_tdata = '0;
  logic [2:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [63:0]  out_tdata;
  logic [2:0]   out_tuser;
  logic         cfg_wr_en = 1'b0;
  logic [30:0]  cfg_wr_data = '0;
  int           fail_count;
  int           results_pending;
  logic         no_idle = 1'b0;

  always #10 clk = ~clk;

  complex_arith_unit_top u_dut (.*);
  complex_arith_checker  u_checker (.*);

  // drain results, idling between words
  always begin
    int gap;
    @(posedge clk);
    while (1) begin
      gap = no_idle ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  task automatic send_word(logic [2:0] func, logic [31:0] ar, logic [31:0] ai,
                           logic [31:0] br, logic [31:0] bi);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= func;
    in_tdata  <= {bi, br, ai, ar};
    do @(posedge clk); while (!in_tready);
  endtask

  // hold until idle, let the pipeline empty, then write the tolerance
  task automatic write_tolerance(logic [30:0] tol);
    in_tvalid <= 1'b0;
    do @(posedge clk); while (results_pending != 0);
    repeat (45) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= tol;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  function automatic logic [31:0] rand_part(int mode);
    case (mode)
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 32'h3F_FFFF)) - 32'sh20_0000);
      2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(0, 3)
                                     : 32'h8000_0000 + $urandom_range(0, 3);
      default: return 32'($signed($urandom_range(0, 32'h3FF)) - 32'sh200);
    endcase
  endfunction

  task automatic random_phase(int n);
    logic [2:0]  func;
    logic [31:0] ar, ai, br, bi;
    int          mode;
    for (int i = 0; i < n; i++) begin
      if (i % 100 == 0) no_idle = ($urandom_range(0, 3) == 0);
      func = $urandom_range(0, 15) == 0 ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
      mode = $urandom_range(0, 3);
      ar = rand_part(mode);
      ai = rand_part($urandom_range(0, 3));
      br = rand_part($urandom_range(0, 3));
      bi = rand_part($urandom_range(0, 3));
      // near-equal operands for the tolerance test
      if (func == cau_pkg::FUNC_EQU && $urandom_range(0, 2) != 0) begin
        br = ar + rand_part(3);
        bi = ai + rand_part(3);
      end
      if (func == cau_pkg::FUNC_DIV && $urandom_range(0, 20) == 0) begin
        br = '0;
        bi = '0;
      end
      send_word(func, ar, ai, br, bi);
    end
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, every operation, special cases
    send_word(cau_pkg::FUNC_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'hFFFF_FFFF);
    send_word(cau_pkg::FUNC_ADD, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    send_word(cau_pkg::FUNC_SUB, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF);
    send_word(cau_pkg::FUNC_SUB, 32'h0001_0000, 32'h0002_0000, 32'h0001_0000, 32'h0000_8000);
    send_word(cau_pkg::FUNC_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_word(cau_pkg::FUNC_MUL, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
    send_word(cau_pkg::FUNC_MUL, 32'h0000_8000, 32'h0, 32'h0000_0001, 32'h0);
    send_word(cau_pkg::FUNC_MUL, 32'hFFFF_8000, 32'h0, 32'h0000_0001, 32'h0);
    send_word(cau_pkg::FUNC_DIV, 32'h0001_0000, 32'h0002_0000, 32'h0, 32'h0);
    send_word(cau_pkg::FUNC_DIV, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'h0);
    send_word(cau_pkg::FUNC_DIV, 32'h0003_0000, 32'hFFFC_0000, 32'h0001_0000, 32'h0002_0000);
    send_word(cau_pkg::FUNC_DIV, 32'h0000_0001, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000);
    send_word(cau_pkg::FUNC_DIV, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_word(cau_pkg::FUNC_MAG, 32'h8000_0000, 32'h8000_0000, 32'h1234_5678, 32'h9ABC_DEF0);
    send_word(cau_pkg::FUNC_MAG, 32'h0000_00B5, 32'h0, 32'h0, 32'h0);
    send_word(cau_pkg::FUNC_EQU, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    send_word(cau_pkg::FUNC_EQU, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
    send_word(cau_pkg::FUNC_EQU, 32'h0001_0000, 32'h0001_0000, 32'h0001_0001, 32'h0001_0000);
    send_word(FuncSpare6, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(FuncSpare7, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1, 32'h1);
    random_phase(300);

    // tolerance of zero never matches
    write_tolerance(31'd0);
    send_word(cau_pkg::FUNC_EQU, 32'h0, 32'h0, 32'h0, 32'h0);
    random_phase(300);

    // widest tolerance
    write_tolerance(31'h7FFF_FFFF);
    send_word(cau_pkg::FUNC_EQU, 32'h8000_0000, 32'h0, 32'h7FFF_FFFF, 32'h0);
    send_word(cau_pkg::FUNC_EQU, 32'hC000_0001, 32'h0, 32'h3FFF_FFFF, 32'h0);
    random_phase(400);

    write_tolerance(31'h0000_0100);
    random_phase(400);

    write_tolerance(31'($urandom_range(0, 32'h7FFF_FFFF)));
    random_phase(400);

    in_tvalid <= 1'b0;
    do @(posedge clk); while (results_pending != 0);
    repeat (60) @(posedge clk);
    if (fail_count == 0 && results_pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #(20 * 500000);
    $display("FAILED: results differ");
    $finish;
  end

endmodule

### complex_arith_unit_top.f
sv/cau_pkg.sv
sv/complex_arith_unit_top.sv
dv/complex_arith_checker.sv
dv/tb_complex_arith_unit_top.sv
